// ===== hdl/jli_pkg.sv =====
// Package for the line indexer: byte codes, class codes, field widths and
// the per-line classification helpers. No dependencies.
`default_nettype none

package jli_pkg;

    // Field widths
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 33;
    localparam int unsigned OUT_LEN_W    = 32;
    localparam int unsigned OUT_OFFSET_W = 48;
    localparam int unsigned CLASS_W      = 2;
    localparam int unsigned BOM_W        = 2;

    // Default position counter width
    localparam int unsigned OFFSET_BITS_DEFAULT = 48;

    // Byte codes
    localparam logic [BYTE_W-1:0] BOM_BYTE0 = 8'hEF;
    localparam logic [BYTE_W-1:0] BOM_BYTE1 = 8'hBB;
    localparam logic [BYTE_W-1:0] BOM_BYTE2 = 8'hBF;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_VT     = 8'h0B;

    // Line classes
    localparam logic [CLASS_W-1:0] CLASS_BLANK      = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_OBJECT     = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NOT_OBJECT = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_TOO_LONG   = 2'd3;

    // Byte order mark progress
    localparam logic [BOM_W-1:0] BOM_NONE    = 2'd0;
    localparam logic [BOM_W-1:0] BOM_SEEN1   = 2'd1;
    localparam logic [BOM_W-1:0] BOM_SEEN2   = 2'd2;
    localparam logic [BOM_W-1:0] BOM_SKIPPED = 2'd3;

    // Saturated length reported for overlong lines
    localparam logic [OUT_LEN_W-1:0] LEN_SAT = '1;

    // Running classification of the current line
    typedef struct packed {
        logic all_ws;
        logic seen;
        logic brace;
    } class_flags_t;

    function automatic logic ascii_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
               (b == CH_CR) || (b == CH_FF) || (b == CH_VT);
    endfunction

    function automatic logic json_ws(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

    // Fold one byte into the line flags
    function automatic class_flags_t classify(input class_flags_t f,
                                              input logic [BYTE_W-1:0] b);
        class_flags_t r;
        r = f;
        if (!ascii_ws(b))
        begin
            r.all_ws = 1'b0;
        end
        if (!f.seen && !json_ws(b))
        begin
            r.seen  = 1'b1;
            r.brace = (b == CH_LBRACE);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jsonl_line_indexer.sv =====
// Line indexer top level: splits a byte stream into lines and emits one
// record per line with offset, length and class. Depends on jli_pkg.
//
// Latency: a record appears on m_* in the cycle after its closing byte is
// accepted. Throughput: one byte per cycle, set by the single pass from the
// line state registers to the record register; s_tready drops only while a
// record waits and m_tready is low. Reset (rst_n low, asynchronous) returns
// all counters and flags to their start values and empties the record register.
`default_nettype none

module jsonl_line_indexer #(
    parameter int unsigned OFFSET_BITS = jli_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_file
    // Line records
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [47:0] line_offset, [79:48] line_length
    output logic [1:0]       m_tuser,   // [1:0] line_class
    output logic             m_tlast    // last_record
);
    import jli_pkg::*;

    // Line state
    logic [OFFSET_BITS-1:0] byte_position_reg, byte_position_next;
    logic [OFFSET_BITS-1:0] line_start_reg, line_start_next;
    logic [LEN_W-1:0]       length_count_reg, length_count_next;
    logic                   on_first_line_reg, on_first_line_next;
    logic [BOM_W-1:0]       bom_progress_reg, bom_progress_next;
    class_flags_t           flags_reg, flags_next;

    // Record register
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_OFFSET_W-1:0] out_offset_reg, out_offset_next;
    logic [OUT_LEN_W-1:0]    out_length_reg, out_length_next;
    logic [CLASS_W-1:0]      out_class_reg, out_class_next;
    logic                    out_last_reg, out_last_next;

    logic         in_accept;
    logic         rec_close;
    logic [LEN_W-1:0] len_inc;
    class_flags_t flags_byte;
    class_flags_t flags_final;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign rec_close = in_accept && ((s_tdata == CH_LF) || s_tlast);

    // Per-byte update and record formation
    always_comb
    begin
        byte_position_next = byte_position_reg;
        line_start_next    = line_start_reg;
        length_count_next  = length_count_reg;
        on_first_line_next = on_first_line_reg;
        bom_progress_next  = bom_progress_reg;
        flags_next         = flags_reg;
        flags_byte         = flags_reg;
        flags_final        = flags_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_offset_next = out_offset_reg;
        out_length_next = out_length_reg;
        out_class_next  = out_class_reg;
        out_last_next   = out_last_reg;

        // Length saturates once it reaches 2^32
        len_inc = length_count_reg[LEN_W-1] ? length_count_reg
                                            : length_count_reg + LEN_W'(1);

        // Byte order mark tracking, then classification
        if (on_first_line_reg && (length_count_reg == LEN_W'(0)) &&
            (s_tdata == BOM_BYTE0))
        begin
            bom_progress_next = BOM_SEEN1;
        end
        else if (on_first_line_reg && (length_count_reg == LEN_W'(1)) &&
                 (bom_progress_reg == BOM_SEEN1) && (s_tdata == BOM_BYTE1))
        begin
            bom_progress_next = BOM_SEEN2;
        end
        else if (on_first_line_reg && (length_count_reg == LEN_W'(2)) &&
                 (bom_progress_reg == BOM_SEEN2) && (s_tdata == BOM_BYTE2))
        begin
            bom_progress_next = BOM_SKIPPED;
        end
        else
        begin
            // A broken mark leaves EF as the first significant byte
            if ((bom_progress_reg == BOM_SEEN1) || (bom_progress_reg == BOM_SEEN2))
            begin
                flags_byte        = classify(flags_byte, BOM_BYTE0);
                bom_progress_next = BOM_NONE;
            end
            flags_byte = classify(flags_byte, s_tdata);
        end

        // Mark still partial at line end counts as EF
        if ((bom_progress_next == BOM_SEEN1) || (bom_progress_next == BOM_SEEN2))
        begin
            flags_final = classify(flags_byte, BOM_BYTE0);
        end
        else
        begin
            flags_final = flags_byte;
        end

        if (in_accept)
        begin
            byte_position_next = byte_position_reg + OFFSET_BITS'(1);
            length_count_next  = len_inc;
            flags_next         = flags_byte;
        end
        else
        begin
            bom_progress_next = bom_progress_reg;
        end

        if (rec_close)
        begin
            out_valid_next  = 1'b1;
            out_offset_next = OUT_OFFSET_W'(line_start_reg);
            out_length_next = len_inc[LEN_W-1] ? LEN_SAT : len_inc[OUT_LEN_W-1:0];
            out_last_next   = s_tlast;
            priority if (len_inc[LEN_W-1])
            begin
                out_class_next = CLASS_TOO_LONG;
            end
            else if (flags_final.all_ws)
            begin
                out_class_next = CLASS_BLANK;
            end
            else if (flags_final.seen && flags_final.brace)
            begin
                out_class_next = CLASS_OBJECT;
            end
            else
            begin
                out_class_next = CLASS_NOT_OBJECT;
            end

            // Start the next line, or the next file after end of file
            length_count_next = '0;
            bom_progress_next = BOM_NONE;
            flags_next        = '{all_ws: 1'b1, seen: 1'b0, brace: 1'b0};
            if (s_tlast)
            begin
                byte_position_next = '0;
                line_start_next    = '0;
                on_first_line_next = 1'b1;
            end
            else
            begin
                line_start_next    = byte_position_reg + OFFSET_BITS'(1);
                on_first_line_next = 1'b0;
            end
        end
    end

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            line_start_reg    <= '0;
            length_count_reg  <= '0;
            on_first_line_reg <= 1'b1;
            bom_progress_reg  <= BOM_NONE;
            flags_reg         <= '{all_ws: 1'b1, seen: 1'b0, brace: 1'b0};
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            line_start_reg    <= line_start_next;
            length_count_reg  <= length_count_next;
            on_first_line_reg <= on_first_line_next;
            bom_progress_reg  <= bom_progress_next;
            flags_reg         <= flags_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Record payload
    always_ff @(posedge clk)
    begin
        out_offset_reg <= out_offset_next;
        out_length_reg <= out_length_next;
        out_class_reg  <= out_class_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_length_reg, out_offset_reg};
    assign m_tuser  = out_class_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    a_too_long_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_class_reg == CLASS_TOO_LONG)) |->
            (out_length_reg == LEN_SAT))
        else $error("too_long record without saturated length");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tlast) |=>
            ((byte_position_reg == '0) && (line_start_reg == '0) && on_first_line_reg))
        else $error("state not restarted after end of file");

    a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !s_tlast && (s_tdata == CH_LF)) |=>
            (!on_first_line_reg && (length_count_reg == '0) &&
             (line_start_reg == byte_position_reg)))
        else $error("line state not cleared after newline");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_count_reg[LEN_W-1] |-> (length_count_reg[LEN_W-2:0] == '0))
        else $error("line length counter beyond saturation");

    a_record_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        rec_close |=> out_valid_reg)
        else $error("line end without record");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for jsonl_line_indexer: streams byte files through the block
// and checks every line record against a predictor of its own.
// Depends on jli_pkg and the jsonl_line_indexer RTL.
`timescale 1ns / 1ps

module tb_top;

    import jli_pkg::*;

    // Expected line record, one per closed line
    typedef struct packed {
        logic [47:0] offset;
        logic [31:0] length;
        logic [1:0]  cls;
        logic        last;
    } line_rec_t;

    localparam logic [LEN_W-1:0] LEN_CAP = 33'h1_0000_0000;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Predictor state
    logic [47:0]       pos_next;
    logic [47:0]       cur_line_start;
    logic [LEN_W-1:0]  line_bytes;
    bit                head_line;
    logic [BOM_W-1:0]  bom_state;
    bit                all_space;
    bit                sig_seen;
    bit                sig_brace;

    line_rec_t line_records_due[$];
    line_rec_t want;
    int        mismatch_count = 0;
    int        bytes_sent     = 0;

    // Sender bursts and receiver stall controls
    int burst_left = 0;
    int gap_max    = 0;
    int stall_pct  = 0;
    int hold_req   = 0;
    int hold_left  = 0;

    jsonl_line_indexer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Generous overall limit
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic void clear_line();
        line_bytes = '0;
        bom_state  = BOM_NONE;
        all_space  = 1'b1;
        sig_seen   = 1'b0;
        sig_brace  = 1'b0;
    endfunction

    function automatic void indexer_reset();
        pos_next       = '0;
        cur_line_start = '0;
        head_line      = 1'b1;
        clear_line();
    endfunction

    // Fold one classified byte into the line flags
    function automatic void note_byte(input logic [7:0] b);
        if (!(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR ||
              b == CH_FF || b == CH_VT))
        begin
            all_space = 1'b0;
        end
        if (!sig_seen && !(b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR))
        begin
            sig_seen  = 1'b1;
            sig_brace = (b == CH_LBRACE);
        end
    endfunction

    // Advance by one byte; returns 1 when a line closes, with its record
    function automatic bit index_byte(input logic [7:0] b, input logic eof,
                                      output line_rec_t rec);
        logic [LEN_W-1:0] at;
        at  = line_bytes;
        rec = '0;
        if (line_bytes < LEN_CAP)
        begin
            line_bytes = line_bytes + LEN_W'(1);
        end

        // Byte order mark only at the head of the file's first line
        if (head_line && at == 0 && b == BOM_BYTE0)
        begin
            bom_state = BOM_SEEN1;
        end
        else if (head_line && at == 1 && bom_state == BOM_SEEN1 && b == BOM_BYTE1)
        begin
            bom_state = BOM_SEEN2;
        end
        else if (head_line && at == 2 && bom_state == BOM_SEEN2 && b == BOM_BYTE2)
        begin
            bom_state = BOM_SKIPPED;
        end
        else
        begin
            // broken mark: its EF counts as the first significant byte
            if (bom_state == BOM_SEEN1 || bom_state == BOM_SEEN2)
            begin
                note_byte(BOM_BYTE0);
                bom_state = BOM_NONE;
            end
            note_byte(b);
        end

        pos_next = pos_next + 48'd1;
        if (b != CH_LF && !eof)
        begin
            return 1'b0;
        end

        // mark cut short by the end of the line
        if (bom_state == BOM_SEEN1 || bom_state == BOM_SEEN2)
        begin
            note_byte(BOM_BYTE0);
        end

        if (line_bytes >= LEN_CAP)
            rec.cls = CLASS_TOO_LONG;
        else if (all_space)
            rec.cls = CLASS_BLANK;
        else if (sig_seen && sig_brace)
            rec.cls = CLASS_OBJECT;
        else
            rec.cls = CLASS_NOT_OBJECT;

        rec.offset = cur_line_start;
        rec.length = (line_bytes >= LEN_CAP) ? LEN_SAT : line_bytes[OUT_LEN_W-1:0];
        rec.last   = eof;

        if (eof)
        begin
            indexer_reset();
        end
        else
        begin
            cur_line_start = pos_next;
            head_line      = 1'b0;
            clear_line();
        end
        return 1'b1;
    endfunction

    // ---------------- receiver and checker ----------------

    // Random stalls, plus a long hold-off counted here on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (line_records_due.size() == 0)
            begin
                $error("line record with none expected: offset %0d length %0d",
                       m_tdata[47:0], m_tdata[79:48]);
                mismatch_count++;
            end
            else
            begin
                want = line_records_due.pop_front();
                if (m_tdata[47:0] !== want.offset)
                begin
                    $error("line_offset: expected %0d, got %0d", want.offset, m_tdata[47:0]);
                    mismatch_count++;
                end
                if (m_tdata[79:48] !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length,
                           m_tdata[79:48]);
                    mismatch_count++;
                end
                if (m_tuser !== want.cls)
                begin
                    $error("line_class: expected %0d, got %0d", want.cls, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_record: expected %0d, got %0d", want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- sender ----------------

    // Offer one byte, in bursts with random gaps, and predict on acceptance
    task automatic send_byte(input logic [7:0] b, input logic eof);
        line_rec_t rec;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gap_max > 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        burst_left--;
        bytes_sent++;
        if (index_byte(b, eof, rec))
        begin
            line_records_due.insert(line_records_due.size(), rec);
        end
    endtask

    task automatic send_run(input logic [7:0] run[$], input bit eof_last);
        for (int k = 0; k < run.size(); k++)
        begin
            send_byte(run[k], eof_last && (k == run.size() - 1));
        end
    endtask

    // Stop offering until every expected record has come out or a wait limit runs out
    task automatic drain_records();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (line_records_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_space(input bit json_only);
        case ($urandom_range(0, json_only ? 2 : 4))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == CH_LF) ? CH_SPACE : b;
    endfunction

    // One file of mixed lines with random content
    task automatic send_random_file();
        int         n_lines;
        int         kind;
        int         n;
        logic [7:0] b;
        logic [7:0] run[$];
        bit         last_line;
        n_lines = $urandom_range(1, 8);
        run.delete();

        // full mark, one cut short, or none
        kind = $urandom_range(0, 9);
        if (kind <= 4)
            run.insert(run.size(), BOM_BYTE0);
        if (kind <= 1 || kind == 4)
            run.insert(run.size(), BOM_BYTE1);
        if (kind <= 1)
            run.insert(run.size(), BOM_BYTE2);

        for (int i = 0; i < n_lines; i++)
        begin
            last_line = (i == n_lines - 1);
            if (i > 0)
                run.delete();
            kind = $urandom_range(0, 9);
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 12);
            if (kind <= 3)
            begin
                // object line
                repeat ($urandom_range(0, 2)) run.insert(run.size(), pick_space(1'b1));
                run.insert(run.size(), CH_LBRACE);
                repeat (n) run.insert(run.size(), text_byte());
            end
            else if (kind <= 5)
            begin
                repeat (n % 7) run.insert(run.size(), pick_space(1'b0));
            end
            else if (kind <= 7)
            begin
                // leading byte that is neither JSON space nor a brace
                repeat ($urandom_range(0, 2)) run.insert(run.size(), pick_space(1'b0));
                b = 8'($urandom_range(0, 255));
                if (b == CH_LBRACE || b == CH_LF || b == CH_SPACE || b == CH_TAB ||
                    b == CH_CR)
                    b = 8'h5B;
                run.insert(run.size(), b);
                repeat (n) run.insert(run.size(), text_byte());
            end
            else
            begin
                // raw noise, sometimes led by a mark in the wrong place
                if ($urandom_range(0, 2) == 0)
                begin
                    run.insert(run.size(), BOM_BYTE0);
                    run.insert(run.size(), BOM_BYTE1);
                    run.insert(run.size(), BOM_BYTE2);
                end
                repeat (n) run.insert(run.size(), 8'($urandom_range(0, 255)));
            end

            if (!last_line || run.size() == 0 || $urandom_range(0, 1) == 0)
                run.insert(run.size(), CH_LF);
            send_run(run, last_line);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_bom_handling();
        logic [7:0] run[$];
        stall_pct = 30;
        gap_max   = 3;
        // full mark then an object, line ends on newline
        run = '{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2, CH_LBRACE, CH_LF};
        send_run(run, 1'b0);
        // end of file right after the first line
        run = '{CH_LF};
        send_run(run, 1'b1);
        // mark broken by a brace
        run = '{BOM_BYTE0, CH_LBRACE, CH_LF};
        send_run(run, 1'b1);
        // mark cut short by the end of file
        run = '{BOM_BYTE0, BOM_BYTE1};
        send_run(run, 1'b1);
        // complete mark alone: blank
        run = '{BOM_BYTE0, BOM_BYTE1, BOM_BYTE2};
        send_run(run, 1'b1);
        drain_records();
    endtask

    task automatic test_line_classes();
        logic [7:0] run[$];
        stall_pct = 0;
        gap_max   = 0;
        run = '{CH_LF};
        send_run(run, 1'b0);
        run = '{CH_CR, CH_FF, CH_VT, CH_TAB, CH_LF};
        send_run(run, 1'b0);
        run = '{CH_SPACE, CH_LBRACE, CH_LF};
        send_run(run, 1'b0);
        // form feed is significant for JSON
        run = '{CH_FF, CH_LBRACE, CH_LF};
        send_run(run, 1'b0);
        // last line without newline, extreme byte values
        run = '{8'h00, 8'hFF};
        send_run(run, 1'b1);
        drain_records();
    endtask

    task automatic test_random_files(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                stall_pct = 0;
                gap_max   = 0;
            end
            else
            begin
                stall_pct = $urandom_range(0, 80);
                gap_max   = $urandom_range(0, 10);
            end
            repeat (4) send_random_file();
        end
        drain_records();
    endtask

    // Receiver holds off while short lines keep coming, so the input stalls
    task automatic test_backpressure();
        logic [7:0] run[$];
        stall_pct = 0;
        gap_max   = 0;
        hold_req  = 300;
        for (int i = 0; i < 70; i++)
        begin
            if (i % 3 == 0)
                run = '{CH_LF};
            else
                run = '{CH_LBRACE, 8'h7D, CH_LF};
            send_run(run, i == 69);
        end
        drain_records();
    endtask

    task automatic test_no_idle(input int target);
        int stop_at;
        stall_pct = 0;
        gap_max   = 0;
        stop_at   = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            send_random_file();
        end
        drain_records();
    endtask

    initial
    begin
        indexer_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bom_handling();
        test_line_classes();
        test_random_files(1250);
        test_backpressure();
        test_no_idle(200);

        repeat (8) @(posedge clk);
        if (line_records_due.size() != 0)
        begin
            $error("%0d line records never came out", line_records_due.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
